[hdl/rv32i_instruction_decoder_unit_assert.svh]
// Assertion macros shared by the decoder's checker.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef RV32I_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RVID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RVID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

[hdl/rvid_pkg.sv]
// Package for the RV32I instruction decoder: opcodes and the result type.
// Depends on nothing; used by the decode, the top level and the checker.
`default_nettype none

package rvid_pkg;

  // Major opcodes of RV32I.
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // Funct3 codes of the immediate shifts and of the SYSTEM class that keep funct7.
  localparam logic [2:0] F3_SLLI   = 3'd1;
  localparam logic [2:0] F3_SRXI   = 3'd5;
  localparam logic [2:0] F3_PRIV   = 3'd0;

  // One decoded instruction.
  typedef struct packed {
    logic        illegal;
    logic [15:0] type_code;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_one;
    logic [4:0]  src_reg_two;
    logic [31:0] imm_value;
  } dec_result_t;

endpackage

`default_nettype wire

[hdl/rvid_if.sv]
// Valid/ready channel interfaces of the decoder: instruction in, result out.
// Depends on nothing.
`default_nettype none

interface rvid_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_instruction;

  modport source (output valid, output raw_instruction, input ready);
  modport sink   (input valid, input raw_instruction, output ready);
endinterface

interface rvid_out_if;
  logic               valid;
  logic               ready;
  logic               illegal;
  logic [15:0]        type_code;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg_one;
  logic [4:0]         src_reg_two;
  logic signed [31:0] imm_value;

  modport source (output valid, output illegal, output type_code, output dest_reg,
                  output src_reg_one, output src_reg_two, output imm_value,
                  input ready);
  modport sink   (input valid, input illegal, input type_code, input dest_reg,
                  input src_reg_one, input src_reg_two, input imm_value,
                  output ready);
endinterface

`default_nettype wire

[hdl/rv32i_instruction_decoder_unit.sv]
// Path: instruction into inst_r, decoded, result into res_r. Throughput: one
// instruction per cycle while out ready holds; the output register stalls on out
// ready and the input register keeps accepting while either stage has room.
// Reset: synchronous active-low rst_n empties both stages; payload is not reset.
// Depends on rvid_pkg, rvid_if and rvid_decode.
`default_nettype none

module rv32i_instruction_decoder_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  rvid_in_if.sink   in_chan,
  rvid_out_if.source out_chan
);

  logic                  in_v_r;
  logic                  in_v_nxt;
  logic [31:0]           inst_r;
  logic                  out_v_r;
  logic                  out_v_nxt;
  rvid_pkg::dec_result_t res_r;
  rvid_pkg::dec_result_t dec_res;
  logic                  out_room;
  logic                  in_room;

  // Each stage moves when the one after it has room.
  assign out_room      = !out_v_r || out_chan.ready;
  assign in_room       = !in_v_r || out_room;
  assign in_chan.ready = in_room;

  rvid_decode u_decode (
    .inst (inst_r),
    .res  (dec_res)
  );

  // Stage occupancy.
  always_comb begin
    in_v_nxt  = in_room ? in_chan.valid : in_v_r;
    out_v_nxt = out_room ? in_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers load on a transaction into their stage.
  always_ff @(posedge clk) begin
    if (in_room && in_chan.valid) begin
      inst_r <= in_chan.raw_instruction;
    end
    if (out_room && in_v_r) begin
      res_r <= dec_res;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.illegal     = res_r.illegal;
  assign out_chan.type_code   = res_r.type_code;
  assign out_chan.dest_reg    = res_r.dest_reg;
  assign out_chan.src_reg_one = res_r.src_reg_one;
  assign out_chan.src_reg_two = res_r.src_reg_two;
  assign out_chan.imm_value   = $signed(res_r.imm_value);

endmodule

`default_nettype wire

[hdl/rvid_decode.sv]
// Combinational RV32I field decode: format, registers, immediate, type code.
// Depends on rvid_pkg.
`default_nettype none

module rvid_decode (
  input  wire logic [31:0]          inst,
  output rvid_pkg::dec_result_t     res
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [15:0] id_full;
  logic [15:0] id_low;
  logic        keep_f7;
  logic [31:0] imm_i;

  assign opc     = inst[6:0];
  assign f3      = inst[14:12];
  // Full type code drops bit 6 of funct7 off the top.
  assign id_full = {inst[30:25], f3, opc};
  assign id_low  = {6'd0, f3, opc};
  assign imm_i   = {{20{inst[31]}}, inst[31:20]};

  // Among I-format opcodes, funct7 survives only for immediate shifts and for SYSTEM with funct3 zero.
  assign keep_f7 = ((opc == rvid_pkg::OPC_OPIMM) &&
                    ((f3 == rvid_pkg::F3_SLLI) || (f3 == rvid_pkg::F3_SRXI))) ||
                   ((opc == rvid_pkg::OPC_SYSTEM) && (f3 == rvid_pkg::F3_PRIV));

  // Format select on the major opcode.
  always_comb begin
    res = '0;
    unique case (opc) inside
      rvid_pkg::OPC_LOAD, rvid_pkg::OPC_FENCE, rvid_pkg::OPC_OPIMM,
      rvid_pkg::OPC_JALR, rvid_pkg::OPC_SYSTEM: begin
        res.dest_reg    = inst[11:7];
        res.src_reg_one = inst[19:15];
        res.type_code   = keep_f7 ? id_full : id_low;
        if ((opc == rvid_pkg::OPC_OPIMM) &&
            ((f3 == rvid_pkg::F3_SLLI) || (f3 == rvid_pkg::F3_SRXI))) begin
          res.imm_value = {27'd0, inst[24:20]};
        end else begin
          res.imm_value = imm_i;
        end
      end
      rvid_pkg::OPC_AUIPC, rvid_pkg::OPC_LUI: begin
        res.dest_reg  = inst[11:7];
        res.imm_value = {inst[31:12], 12'd0};
        res.type_code = {9'd0, opc};
      end
      rvid_pkg::OPC_STORE: begin
        res.src_reg_one = inst[19:15];
        res.src_reg_two = inst[24:20];
        res.imm_value   = {{20{inst[31]}}, inst[31:25], inst[11:7]};
        res.type_code   = id_low;
      end
      rvid_pkg::OPC_OP: begin
        res.dest_reg    = inst[11:7];
        res.src_reg_one = inst[19:15];
        res.src_reg_two = inst[24:20];
        res.type_code   = id_full;
      end
      rvid_pkg::OPC_BRANCH: begin
        res.src_reg_one = inst[19:15];
        res.src_reg_two = inst[24:20];
        res.imm_value   = {{19{inst[31]}}, inst[31], inst[7], inst[30:25],
                           inst[11:8], 1'b0};
        res.type_code   = id_low;
      end
      rvid_pkg::OPC_JAL: begin
        res.dest_reg  = inst[11:7];
        res.imm_value = {{11{inst[31]}}, inst[31], inst[19:12], inst[20],
                         inst[30:21], 1'b0};
        res.type_code = {9'd0, opc};
      end
      default: begin
        res.illegal = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/rvid_checker.sv]
// Port-level checker for the decoder, bound to its top level.
// Depends on rvid_pkg and rv32i_instruction_decoder_unit_assert.svh.
`default_nettype none
`include "rv32i_instruction_decoder_unit_assert.svh"

module rvid_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        illegal,
  input wire logic [15:0] type_code,
  input wire logic [4:0]  dest_reg,
  input wire logic [4:0]  src_reg_one,
  input wire logic [4:0]  src_reg_two,
  input wire logic [31:0] imm_value
);

  logic fields_clear;
  logic is_rtype;

  // Every field but the illegal flag reads zero.
  assign fields_clear = (type_code == 16'd0) && (dest_reg == 5'd0) &&
                        (src_reg_one == 5'd0) && (src_reg_two == 5'd0) &&
                        (imm_value == 32'd0);

  // The opcode part of the type code names a register-register instruction.
  assign is_rtype = (type_code[6:0] == rvid_pkg::OPC_OP);

  // A stalled result transaction stays offered.
  `RVID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // An illegal instruction clears every other field.
  `RVID_ASSERT_NOW(a_illegal_clear, out_valid && illegal, fields_clear)

  // Every legal RV32I opcode ends in binary 11.
  `RVID_ASSERT_NOW(a_legal_low_bits, out_valid && !illegal, type_code[1:0] == 2'b11)

  // Register-register instructions carry no immediate.
  `RVID_ASSERT_NOW(a_rtype_no_imm, out_valid && !illegal && is_rtype, imm_value == 32'd0)

endmodule

bind rv32i_instruction_decoder_unit rvid_checker u_rvid_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .illegal     (out_chan.illegal),
  .type_code   (out_chan.type_code),
  .dest_reg    (out_chan.dest_reg),
  .src_reg_one (out_chan.src_reg_one),
  .src_reg_two (out_chan.src_reg_two),
  .imm_value   (out_chan.imm_value)
);

`default_nettype wire
